// ===== design/mnhr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the mesh next-hop resolver.
// No dependencies; imported by every module of the block.
package mnhr_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int IP_W              = 32;
    localparam int HOP_W             = 8;
    localparam int STATUS_W          = 3;
    localparam int OP_W              = 2;

    localparam logic [OP_W-1:0] OP_RESOLVE   = 2'd0;
    localparam logic [OP_W-1:0] OP_ROUTE_SET = 2'd1;
    localparam logic [OP_W-1:0] OP_CHILD_SET = 2'd2;

    localparam logic [STATUS_W-1:0] ST_PARENT  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CHILD   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_XLATE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOROUTE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd6;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PARENT,
        S_SCAN,
        S_RESULT
    } state_t;

    typedef enum logic [2:0] {
        K_CHILD_LOOKUP,
        K_ROUTE_LOOKUP,
        K_HOP_XLATE,
        K_ROUTE_UPD,
        K_CHILD_UPD
    } scan_kind_t;

endpackage

// ===== design/mnhr_table.sv =====
`timescale 1ns / 1ps
// Exact-match table storage: key/data memory with registered read and fill count.
// Depends on mnhr_pkg.
module mnhr_table import mnhr_pkg::*; #(
    parameter int ENTRIES = TABLE_ENTRIES_DEF,
    parameter int DATA_W  = IP_W,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [IP_W-1:0]   rd_key,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic              wr_append,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [IP_W-1:0]   wr_key,
    input  logic [DATA_W-1:0] wr_data,
    output logic [CNT_W-1:0]  count
);

    logic [IP_W+DATA_W-1:0] mem [ENTRIES];
    logic [IP_W+DATA_W-1:0] rd_word_reg;
    logic [CNT_W-1:0]       count_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_key, wr_data};
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // New entries are only ever appended, so the count alone marks what is valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (wr_en && wr_append) begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    assign rd_key  = rd_word_reg[IP_W+DATA_W-1:DATA_W];
    assign rd_data = rd_word_reg[DATA_W-1:0];
    assign count   = count_reg;

endmodule

// ===== design/mesh_next_hop_resolver_core.sv =====
`timescale 1ns / 1ps
// Top level of the mesh next-hop resolver: sequencer, shared key comparator, I/O registers.
// Depends on mnhr_pkg and mnhr_table.

// The resolver keeps a route table (destination -> next hop and hop count) and a
// children table (child AP address -> child STA address), each TABLE_ENTRIES deep.
// Operation 0 resolves a destination: it checks the parent address, then the
// children table, then the route table, and translates a route's next hop through
// the children table when the next hop is a child. Operations 1 and 2 add or
// overwrite a route or a child entry; a new key offered to a full table is refused
// with status 7. Operation 3 answers "no route". Each input transfer yields exactly
// one result transfer. The block handles one item at a time: a single 32-bit
// comparator walks the tables one entry per cycle from a memory with a registered
// read port; the last compare lands the cycle after the last read, and a miss is
// declared the cycle after that. A lookup runs the parent check and then the child,
// route and next-hop scans as needed, an update one scan of its own table and the
// unused operation no scan at all; each of these takes longer while an earlier
// result still waits in the output register. s_ready is high only while the
// sequencer is idle; a finished result sits in the output register, and the next
// item can be taken while it waits. parent_ip is written through
// cfg_wr_en/cfg_wr_data and must only change while no transfer is in flight.
// Tables need no clearing after reset: their fill counts reset to zero and only
// filled entries are ever read.
module mesh_next_hop_resolver_core import mnhr_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [IP_W-1:0]     cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [IP_W-1:0]     s_key_ip,
    input  logic [IP_W-1:0]     s_next_hop_ip,
    input  logic [HOP_W-1:0]    s_hop_distance,
    input  logic [IP_W-1:0]     s_station_ip,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [IP_W-1:0]     m_route_ip
);

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int RDATA_W = IP_W + HOP_W;

    // Configuration register.
    logic [IP_W-1:0] parent_ip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parent_ip_reg <= '0;
        end else if (cfg_wr_en) begin
            parent_ip_reg <= cfg_wr_data;
        end
    end

    // Sequencer state and captured item.
    state_t     state_reg, state_next;
    scan_kind_t kind_reg, kind_next;

    logic [IP_W-1:0]     key_reg, key_next;
    logic [IP_W-1:0]     nh_reg, nh_next;
    logic [HOP_W-1:0]    hops_reg, hops_next;
    logic [IP_W-1:0]     sta_reg, sta_next;
    logic [IP_W-1:0]     scan_key_reg, scan_key_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [IP_W-1:0]     rip_reg, rip_next;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [IP_W-1:0]     m_route_ip_reg, m_route_ip_next;

    // Table ports.
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [IP_W-1:0]    child_rd_key, route_rd_key;
    logic [IP_W-1:0]    child_rd_data;
    logic [RDATA_W-1:0] route_rd_data;
    logic [CNT_W-1:0]   child_count, route_count;
    logic               child_wr_en, route_wr_en, wr_append;
    logic [IDX_W-1:0]   wr_addr;

    mnhr_table #(
        .ENTRIES (TABLE_ENTRIES),
        .DATA_W  (IP_W)
    ) u_child_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_key    (child_rd_key),
        .rd_data   (child_rd_data),
        .wr_en     (child_wr_en),
        .wr_append (wr_append),
        .wr_addr   (wr_addr),
        .wr_key    (key_reg),
        .wr_data   (sta_reg),
        .count     (child_count)
    );

    mnhr_table #(
        .ENTRIES (TABLE_ENTRIES),
        .DATA_W  (RDATA_W)
    ) u_route_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_key    (route_rd_key),
        .rd_data   (route_rd_data),
        .wr_en     (route_wr_en),
        .wr_append (wr_append),
        .wr_addr   (wr_addr),
        .wr_key    (key_reg),
        .wr_data   ({nh_reg, hops_reg}),
        .count     (route_count)
    );

    // The child-table scans and the route-table scans share one walk and one
    // comparator; the scan kind picks which table feeds them.
    logic            use_child;
    logic [CNT_W-1:0] sel_count;
    logic [IP_W-1:0] sel_rd_key;
    logic [IP_W-1:0] cmp_a, cmp_b;
    logic            key_eq;
    logic            issue;
    logic            scan_hit, scan_miss;
    logic            table_full;

    assign use_child  = (kind_reg == K_CHILD_LOOKUP) || (kind_reg == K_HOP_XLATE) ||
                        (kind_reg == K_CHILD_UPD);
    assign sel_count  = use_child ? child_count : route_count;
    assign sel_rd_key = use_child ? child_rd_key : route_rd_key;

    assign cmp_a  = (state_reg == S_PARENT) ? key_reg : sel_rd_key;
    assign cmp_b  = (state_reg == S_PARENT) ? parent_ip_reg : scan_key_reg;
    assign key_eq = (cmp_a == cmp_b);

    // One read is issued per cycle; its compare happens the cycle after.
    assign issue     = (state_reg == S_SCAN) && (scan_idx_reg < sel_count);
    assign rd_en     = issue;
    assign rd_addr   = scan_idx_reg[IDX_W-1:0];
    assign scan_hit  = (state_reg == S_SCAN) && cmp_vld_reg && key_eq;
    assign scan_miss = (state_reg == S_SCAN) && !cmp_vld_reg && !issue;

    assign table_full = (sel_count == CNT_W'(TABLE_ENTRIES));

    // A hit overwrites the matching entry in place; a miss appends at the count unless the table is full.
    assign wr_append   = scan_miss && !table_full;
    assign wr_addr     = scan_hit ? cmp_idx_reg : sel_count[IDX_W-1:0];
    assign route_wr_en = (kind_reg == K_ROUTE_UPD) && (scan_hit || wr_append);
    assign child_wr_en = (kind_reg == K_CHILD_UPD) && (scan_hit || wr_append);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_operation == OP_RESOLVE) begin
                        state_next = S_PARENT;
                    end else if (s_operation == OP_ROUTE_SET ||
                                 s_operation == OP_CHILD_SET) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_PARENT: begin
                state_next = key_eq ? S_RESULT : S_SCAN;
            end
            S_SCAN: begin
                if (scan_hit) begin
                    state_next = (kind_reg == K_ROUTE_LOOKUP) ? S_SCAN : S_RESULT;
                end else if (scan_miss) begin
                    state_next = (kind_reg == K_CHILD_LOOKUP) ? S_SCAN : S_RESULT;
                end
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        key_next        = key_reg;
        nh_next         = nh_reg;
        hops_next       = hops_reg;
        sta_next        = sta_reg;
        kind_next       = kind_reg;
        scan_key_next   = scan_key_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        status_next     = status_reg;
        rip_next        = rip_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_route_ip_next = m_route_ip_reg;

        if (issue) begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
            cmp_vld_next  = 1'b1;
            cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    key_next      = s_key_ip;
                    nh_next       = s_next_hop_ip;
                    hops_next     = s_hop_distance;
                    sta_next      = s_station_ip;
                    scan_key_next = s_key_ip;
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                    status_next   = ST_NOROUTE;
                    rip_next      = '0;
                    kind_next     = (s_operation == OP_CHILD_SET) ? K_CHILD_UPD
                                                                  : K_ROUTE_UPD;
                end
            end
            S_PARENT: begin
                if (key_eq) begin
                    status_next = ST_PARENT;
                    rip_next    = parent_ip_reg;
                end else begin
                    kind_next     = K_CHILD_LOOKUP;
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    unique case (kind_reg)
                        K_CHILD_LOOKUP: begin
                            status_next = ST_CHILD;
                            rip_next    = child_rd_data;
                        end
                        K_ROUTE_LOOKUP: begin
                            // Found the route; now see whether its next hop is a child.
                            rip_next      = route_rd_data[RDATA_W-1:HOP_W];
                            scan_key_next = route_rd_data[RDATA_W-1:HOP_W];
                            kind_next     = K_HOP_XLATE;
                            scan_idx_next = '0;
                            cmp_vld_next  = 1'b0;
                        end
                        K_HOP_XLATE: begin
                            status_next = ST_XLATE;
                            rip_next    = child_rd_data;
                        end
                        K_ROUTE_UPD, K_CHILD_UPD: begin
                            status_next = ST_UPDATED;
                        end
                        default: status_next = ST_NOROUTE;
                    endcase
                end else if (scan_miss) begin
                    unique case (kind_reg)
                        K_CHILD_LOOKUP: begin
                            kind_next     = K_ROUTE_LOOKUP;
                            scan_idx_next = '0;
                            cmp_vld_next  = 1'b0;
                        end
                        K_ROUTE_LOOKUP: begin
                            status_next = ST_NOROUTE;
                            rip_next    = '0;
                        end
                        K_HOP_XLATE: begin
                            // Next hop is not a child: the stored next hop stands.
                            status_next = ST_TABLE;
                        end
                        K_ROUTE_UPD, K_CHILD_UPD: begin
                            status_next = table_full ? ST_FULL : ST_ADDED;
                        end
                        default: status_next = ST_NOROUTE;
                    endcase
                end
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_status_next   = status_reg;
                    m_route_ip_next = rip_reg;
                end
            end
            default: begin
                status_next = ST_NOROUTE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        nh_reg         <= nh_next;
        hops_reg       <= hops_next;
        sta_reg        <= sta_next;
        kind_reg       <= kind_next;
        scan_key_reg   <= scan_key_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        status_reg     <= status_next;
        rip_reg        <= rip_next;
        m_status_reg   <= m_status_next;
        m_route_ip_reg <= m_route_ip_next;
    end

    // Unknown operation codes fall through to the "no route" answer set on capture.
    assign s_ready    = (state_reg == S_IDLE);

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_route_ip = m_route_ip_reg;

endmodule

// ===== bench/mesh_next_hop_resolver_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for mesh_next_hop_resolver_core: queue-fed driver, checking monitor.
// Depends on mnhr_pkg and the resolver RTL; needs no files or arguments.
module mesh_next_hop_resolver_core_test;
    import mnhr_pkg::*;

    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int POOL_SIZE = 32;
    localparam int DRAIN_CYCLES = 60;     // settle time, longer than a full lookup
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off in the pressure phase
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 390;

    typedef enum logic [2:0] {
        PACE_FREE,
        PACE_SENDER_GAPS,
        PACE_RECEIVER_STALLS,
        PACE_BOTH,
        PACE_HOLD_OFF
    } pace_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IP_W-1:0]  key;
        logic [IP_W-1:0]  next_hop;
        logic [HOP_W-1:0] hops;
        logic [IP_W-1:0]  station;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IP_W-1:0]     route_ip;
    } answer_t;

    // Clock, reset and every block input start at known values.
    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [IP_W-1:0]     cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation = '0;
    logic [IP_W-1:0]     s_key_ip = '0;
    logic [IP_W-1:0]     s_next_hop_ip = '0;
    logic [HOP_W-1:0]    s_hop_distance = '0;
    logic [IP_W-1:0]     s_station_ip = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [IP_W-1:0]     m_route_ip;

    // Shadow copy of the resolver's tables and register.
    logic [IP_W-1:0]  parent_model = '0;
    logic [IP_W-1:0]  route_key_m      [TABLE_ENTRIES];
    logic [IP_W-1:0]  route_next_hop_m [TABLE_ENTRIES];
    logic [HOP_W-1:0] route_hops_m     [TABLE_ENTRIES];
    int               route_count_m = 0;
    logic [IP_W-1:0]  child_ap_m       [TABLE_ENTRIES];
    logic [IP_W-1:0]  child_sta_m      [TABLE_ENTRIES];
    int               child_count_m = 0;

    request_t requests_to_send[$];
    answer_t  answers_due[$];
    logic [IP_W-1:0] addr_pool [POOL_SIZE];

    pace_t pace = PACE_FREE;
    int    failures = 0;
    int    requests_sent = 0;
    int    answers_checked = 0;
    int    status_seen [8];
    int    hold_count = 0;
    logic  hold_done = 1'b0;
    int    cycle_count = 0;

    mesh_next_hop_resolver_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_key_ip      (s_key_ip),
        .s_next_hop_ip (s_next_hop_ip),
        .s_hop_distance(s_hop_distance),
        .s_station_ip  (s_station_ip),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_route_ip    (m_route_ip)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int find_route(input logic [IP_W-1:0] key);
        for (int i = 0; i < route_count_m; i++) begin
            if (route_key_m[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic int find_child(input logic [IP_W-1:0] key);
        for (int i = 0; i < child_count_m; i++) begin
            if (child_ap_m[i] == key) return i;
        end
        return -1;
    endfunction

    // Applies one request to the shadow tables and returns the answer it must produce.
    // A lookup tries the parent first, then a direct child, then a route whose next
    // hop is swapped for the child's STA address when that next hop is a child.
    function automatic answer_t apply_mesh_request(input request_t req);
        answer_t ans;
        int      ci;
        int      ri;
        int      hi;
        ans.status = ST_NOROUTE;
        ans.route_ip = '0;
        case (req.op)
            OP_RESOLVE: begin
                ci = find_child(req.key);
                ri = find_route(req.key);
                if (req.key == parent_model) begin
                    ans.status = ST_PARENT;
                    ans.route_ip = parent_model;
                end else if (ci >= 0) begin
                    ans.status = ST_CHILD;
                    ans.route_ip = child_sta_m[ci];
                end else if (ri >= 0) begin
                    hi = find_child(route_next_hop_m[ri]);
                    if (hi >= 0) begin
                        ans.status = ST_XLATE;
                        ans.route_ip = child_sta_m[hi];
                    end else begin
                        ans.status = ST_TABLE;
                        ans.route_ip = route_next_hop_m[ri];
                    end
                end
            end
            OP_ROUTE_SET: begin
                ri = find_route(req.key);
                if (ri >= 0) begin
                    route_next_hop_m[ri] = req.next_hop;
                    route_hops_m[ri] = req.hops;
                    ans.status = ST_UPDATED;
                end else if (route_count_m >= TABLE_ENTRIES) begin
                    ans.status = ST_FULL;
                end else begin
                    route_key_m[route_count_m] = req.key;
                    route_next_hop_m[route_count_m] = req.next_hop;
                    route_hops_m[route_count_m] = req.hops;
                    route_count_m++;
                    ans.status = ST_ADDED;
                end
            end
            OP_CHILD_SET: begin
                ci = find_child(req.key);
                if (ci >= 0) begin
                    child_sta_m[ci] = req.station;
                    ans.status = ST_UPDATED;
                end else if (child_count_m >= TABLE_ENTRIES) begin
                    ans.status = ST_FULL;
                end else begin
                    child_ap_m[child_count_m] = req.key;
                    child_sta_m[child_count_m] = req.station;
                    child_count_m++;
                    ans.status = ST_ADDED;
                end
            end
            default: begin
                // The unused operation leaves the tables alone.
            end
        endcase
        return ans;
    endfunction

    function automatic logic sender_gap();
        case (pace)
            PACE_SENDER_GAPS: return $urandom_range(0, 99) < 48;
            PACE_BOTH:        return $urandom_range(0, 99) < 23;
            default:          return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stall();
        case (pace)
            PACE_RECEIVER_STALLS: return $urandom_range(0, 99) < 48;
            PACE_BOTH:            return $urandom_range(0, 99) < 23;
            default:              return 1'b0;
        endcase
    endfunction

    // Address picker: mostly the shared pool so that keys hit, sometimes the
    // all-zero and all-one addresses, sometimes anything at all.
    function automatic logic [IP_W-1:0] pick_addr(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 6) return '1;
        if (r < 84) return addr_pool[$urandom_range(lo, hi)];
        return $urandom;
    endfunction

    // Random requests are mostly well formed: child keys come from the low part of
    // the pool, route keys from the high part, and the two ranges overlap so that a
    // key can sit in both tables. Both ranges exceed the table depth, so the tables
    // fill and new keys are refused.
    function automatic request_t random_request();
        request_t req;
        int       r;
        req.op = OP_UNUSED;
        req.key = $urandom;
        req.next_hop = $urandom;
        req.hops = HOP_W'($urandom_range(0, 255));
        req.station = $urandom;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            req.op = OP_W'($urandom_range(0, 3));
        end else if (r < 10) begin
            req.op = OP_UNUSED;
        end else if (r < 45) begin
            req.op = OP_RESOLVE;
            if ($urandom_range(0, 9) == 0) req.key = parent_model;
            else req.key = pick_addr(0, POOL_SIZE - 1);
        end else if (r < 72) begin
            req.op = OP_ROUTE_SET;
            req.key = pick_addr(8, POOL_SIZE - 1);
            if ($urandom_range(0, 1) == 0) req.next_hop = pick_addr(0, 19);
            else req.next_hop = pick_addr(0, POOL_SIZE - 1);
        end else begin
            req.op = OP_CHILD_SET;
            req.key = pick_addr(0, 19);
        end
        return req;
    endfunction

    // Driver: a new request is presented once the previous one has been taken.
    // The prediction is made at the edge where the transfer happens.
    always @(posedge aclk) begin
        request_t next_req;
        request_t taken;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                taken.op = s_operation;
                taken.key = s_key_ip;
                taken.next_hop = s_next_hop_ip;
                taken.hops = s_hop_distance;
                taken.station = s_station_ip;
                answers_due.push_back(apply_mesh_request(taken));
                requests_sent++;
            end
            if (!s_valid || s_ready) begin
                if (requests_to_send.size() > 0 && !sender_gap()) begin
                    next_req = requests_to_send.pop_front();
                    s_valid <= 1'b1;
                    s_operation <= next_req.op;
                    s_key_ip <= next_req.key;
                    s_next_hop_ip <= next_req.next_hop;
                    s_hop_distance <= next_req.hops;
                    s_station_ip <= next_req.station;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result transfer against the oldest expected answer and
    // paces m_ready. In the hold-off phase it keeps m_ready low for a long stretch
    // so that the output register fills and the block stops taking requests.
    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                answers_checked++;
                status_seen[m_status]++;
                if (answers_due.size() == 0) begin
                    $display("%0t: result with nothing expected: status %0d route_ip %h",
                             $time, m_status, m_route_ip);
                    failures++;
                end else begin
                    want = answers_due.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, m_status);
                        failures++;
                    end
                    if (m_route_ip !== want.route_ip) begin
                        $display("%0t: route_ip mismatch: expected %h actual %h",
                                 $time, want.route_ip, m_route_ip);
                        failures++;
                    end
                end
            end
            if (pace == PACE_HOLD_OFF && !hold_done) begin
                m_ready <= 1'b0;
                hold_count <= hold_count + 1;
                if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
            end else begin
                m_ready <= !receiver_stall();
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles, %0d answers outstanding",
                     $time, CYCLE_LIMIT, answers_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic queue_request(input logic [OP_W-1:0] op, input logic [IP_W-1:0] key,
                                 input logic [IP_W-1:0] next_hop,
                                 input logic [HOP_W-1:0] hops,
                                 input logic [IP_W-1:0] station);
        request_t req;
        req.op = op;
        req.key = key;
        req.next_hop = next_hop;
        req.hops = hops;
        req.station = station;
        requests_to_send.push_back(req);
    endtask

    // The parent register may only change while no transfer is in flight; callers
    // make sure the block has drained first.
    task automatic write_parent(input logic [IP_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        parent_model = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every request has been sent and answered, then lets the block
    // settle for a full lookup time.
    task automatic drain();
        while (requests_to_send.size() != 0 || s_valid || answers_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic run_random_phase(input pace_t mode, input logic [IP_W-1:0] parent,
                                    input int count);
        write_parent(parent);
        @(negedge aclk);
        pace = mode;
        for (int i = 0; i < count; i++) requests_to_send.push_back(random_request());
        drain();
    endtask

    localparam logic [IP_W-1:0] AP_A   = 32'h0A00_0001;
    localparam logic [IP_W-1:0] STA_1  = 32'hC0A8_0401;
    localparam logic [IP_W-1:0] STA_2  = 32'hC0A8_0402;
    localparam logic [IP_W-1:0] DEST_1 = 32'h0A00_0101;
    localparam logic [IP_W-1:0] DEST_2 = 32'h0A00_0102;
    localparam logic [IP_W-1:0] HOP_N  = 32'h0A00_0203;

    initial begin
        for (int i = 0; i < 8; i++) status_seen[i] = 0;
        for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, parent still at its reset value of zero.
        pace = PACE_FREE;
        queue_request(OP_RESOLVE, '0, '1, 8'hFF, '1);         // parent at reset
        queue_request(OP_RESOLVE, '1, '0, 8'h00, '0);         // missing route
        queue_request(OP_UNUSED, '1, '1, 8'hFF, '1);          // unused operation
        queue_request(OP_UNUSED, '0, '0, 8'h00, '0);
        queue_request(OP_CHILD_SET, AP_A, '1, 8'hFF, STA_1);  // child added
        queue_request(OP_CHILD_SET, AP_A, '0, 8'h00, STA_2);  // child overwritten
        queue_request(OP_RESOLVE, AP_A, '0, 8'h00, '0);       // direct child
        queue_request(OP_ROUTE_SET, DEST_1, AP_A, 8'hFF, '1); // next hop is a child
        queue_request(OP_RESOLVE, DEST_1, '0, 8'h00, '0);     // translated hop
        queue_request(OP_ROUTE_SET, DEST_2, HOP_N, 8'h00, '0);
        queue_request(OP_RESOLVE, DEST_2, '1, 8'hFF, '1);     // hop from the table
        queue_request(OP_ROUTE_SET, DEST_2, '1, 8'h7F, '0);   // route overwritten
        queue_request(OP_RESOLVE, DEST_2, '0, 8'h00, '0);
        queue_request(OP_ROUTE_SET, '1, '0, 8'h80, '1);
        queue_request(OP_RESOLVE, '1, '0, 8'h00, '0);
        queue_request(OP_CHILD_SET, '0, '0, 8'h00, '1);       // parent still wins on key 0
        queue_request(OP_RESOLVE, '0, '0, 8'h00, '0);
        queue_request(OP_ROUTE_SET, AP_A, HOP_N, 8'h01, '0);  // key in both tables
        queue_request(OP_RESOLVE, AP_A, '0, 8'h00, '0);       // child has priority
        queue_request(OP_CHILD_SET, '1, '1, 8'hFF, '0);
        queue_request(OP_RESOLVE, '1, '1, 8'hFF, '1);
        drain();
        write_parent('0);

        // Random phases, each with its own parent address and idling pattern.
        run_random_phase(PACE_FREE, '1, PHASE_ITEMS);
        run_random_phase(PACE_SENDER_GAPS, addr_pool[$urandom_range(0, 19)], PHASE_ITEMS);
        run_random_phase(PACE_RECEIVER_STALLS, $urandom, PHASE_ITEMS);
        run_random_phase(PACE_BOTH, '0, PHASE_ITEMS);
        run_random_phase(PACE_HOLD_OFF, addr_pool[$urandom_range(8, 31)], PHASE_ITEMS);

        $display("Sent %0d requests and checked %0d answers under five pacing patterns.",
                 requests_sent, answers_checked);
        $display("Answers by status 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
        if (failures == 0 && answers_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/mnhr_pkg.sv
design/mnhr_table.sv
design/mesh_next_hop_resolver_core.sv
bench/mesh_next_hop_resolver_core_test.sv
